### hdl/vas_pkg.sv
`timescale 1ns / 1ps
// vas_pkg: shared types and codes of the voice allocator
// no dependencies; imported by every module of the block
package vas_pkg;

    // one sounding note as held in the note table
    typedef struct packed {
        logic       midi;
        logic [4:0] kcode;
        logic [6:0] knum;
        logic [3:0] chan;
        logic       pool;
        logic [3:0] voice;
    } t_note;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_STEAL = 2'd1,
        KIND_REL   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // one result item
    typedef struct packed {
        t_kind      kind;
        logic       midi;
        logic [4:0] kcode;
        logic [6:0] knum;
        logic [3:0] chan;
        logic       pool;
        logic [3:0] voice;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_EMIT0,
        ST_EMIT1
    } t_state;

    // per-cell control of the note queue
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    // control of one free voice list
    typedef struct packed {
        logic rebuild;
        logic poly;
        logic pop;
        logic push;
    } t_fl_ctrl;

    localparam logic MODE_PRESS   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;
    localparam logic POOL_FM      = 1'b0;
    localparam logic POOL_SSG     = 1'b1;

endpackage

### hdl/vas_note_cell.sv
`timescale 1ns / 1ps
// vas_note_cell: one entry of the note queue, shifts toward the head or loads a new note
// depends on vas_pkg
module vas_note_cell (
    input  logic                i_clk,
    input  vas_pkg::t_cell_ctrl i_ctrl,
    input  vas_pkg::t_note      i_next,
    input  vas_pkg::t_note      i_new,
    output vas_pkg::t_note      o_q
);
    import vas_pkg::*;

    t_note r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_q <= i_new;
        end else if (i_ctrl.shift) begin
            r_q <= i_next;
        end
    end

    assign o_q = r_q;

endmodule

### hdl/vas_free_list.sv
`timescale 1ns / 1ps
// vas_free_list: free voice stack of one pool, pop and push at the front
// depends on vas_pkg
module vas_free_list #(
    parameter int N    = 6,
    parameter int LW   = 3,
    parameter int CNTW = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vas_pkg::t_fl_ctrl i_ctrl,
    input  logic [LW-1:0]     i_push_voice,
    output logic [LW-1:0]     o_head,
    output logic [CNTW-1:0]   o_count
);
    import vas_pkg::*;

    logic [LW-1:0]   r_list [N];
    logic [CNTW-1:0] r_count;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_slot
            logic [LW-1:0] w_up;
            logic [LW-1:0] w_down;
            if (gi == N - 1) begin : g_end
                assign w_up = r_list[gi];
            end else begin : g_mid
                assign w_up = r_list[gi+1];
            end
            if (gi == 0) begin : g_front
                assign w_down = i_push_voice;
            end else begin : g_rest
                assign w_down = r_list[gi-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n || i_ctrl.rebuild) begin
                    r_list[gi] <= LW'(gi);
                end else if (i_ctrl.push) begin
                    r_list[gi] <= w_down;
                end else if (i_ctrl.pop) begin
                    r_list[gi] <= w_up;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNTW'(N);
        end else if (i_ctrl.rebuild) begin
            r_count <= i_ctrl.poly ? CNTW'(N) : CNTW'(1);
        end else if (i_ctrl.push) begin
            if (r_count != CNTW'(N)) begin
                r_count <= r_count + CNTW'(1);
            end
        end else if (i_ctrl.pop) begin
            r_count <= r_count - CNTW'(1);
        end
    end

    assign o_head  = r_list[0];
    assign o_count = r_count;

endmodule

### hdl/voice_allocator_with_stealing_unit.sv
`timescale 1ns / 1ps
// voice_allocator_with_stealing_unit: top level, note queue of cells, two free lists, control
// depends on vas_pkg, vas_note_cell, vas_free_list
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata key fields, tuser mode/is_midi
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata note and voice, tuser kind, tlast
//  cfg       in         i_cfg_we                       i_cfg_wdata poly_mode
//
// for each item the note queue rotates once through its head cell, one note a cycle,
// over all sounding notes; then a commit state builds the results, and each result
// in turn moves into the output register.
// reset and a write of i_cfg_wdata empty the note queue and rebuild both free lists.
// a stalled output holds the queue in its emit state; the next item is taken once the
// final result sits in the output register.
module voice_allocator_with_stealing_unit #(
    parameter int FM_VOICES  = 6,
    parameter int SSG_VOICES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // key_code, key_number, track_channel, pool, zero pad
    input  logic [1:0]  s_axis_tuser,  // mode, is_midi
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_key_code, out_key_number, out_track_channel,
                                       // out_pool, voice, zero pad
    output logic [2:0]  m_axis_tuser,  // kind, out_is_midi
    output logic        m_axis_tlast
);
    import vas_pkg::*;

    localparam int D       = FM_VOICES + SSG_VOICES;
    localparam int CW      = $clog2(D + 1);
    localparam int FM_LW   = (FM_VOICES > 1) ? $clog2(FM_VOICES) : 1;
    localparam int SSG_LW  = (SSG_VOICES > 1) ? $clog2(SSG_VOICES) : 1;
    localparam int FM_CW   = $clog2(FM_VOICES + 1);
    localparam int SSG_CW  = $clog2(SSG_VOICES + 1);

    t_state  r_state, n_state;
    logic    r_poly;
    logic [CW-1:0] r_len, r_n, r_step;
    t_note   r_in;
    logic    r_mode;
    logic    r_found;
    t_note   r_hit;
    t_res    r_res0, r_res1, n_res0, n_res1;
    logic    r_two, n_two;
    logic    r_out_valid;
    t_res    r_out;
    logic    r_out_last;

    // control strobes
    logic w_accept, w_step, w_commit, w_load0, w_load1, w_out_free;

    // note queue
    t_note      w_cell [D];
    t_cell_ctrl w_cctrl [D];
    t_note      w_head;
    logic       w_pred, w_hit_now;
    logic       w_q_push;
    logic [CW-1:0] w_tail;
    t_note      w_push_note;

    // free lists
    t_fl_ctrl          w_fm_ctrl, w_ssg_ctrl;
    logic [FM_LW-1:0]  w_fm_head;
    logic [SSG_LW-1:0] w_ssg_head;
    logic [FM_CW-1:0]  w_fm_cnt;
    logic [SSG_CW-1:0] w_ssg_cnt;
    logic              w_cnt_pos;
    logic [3:0]        w_pool_head;

    // commit decisions
    logic  w_is_rel, w_fresh, w_replace, w_none;
    t_note w_new;

    assign w_head      = w_cell[0];
    assign w_cnt_pos   = (r_in.pool == POOL_SSG) ? (w_ssg_cnt != '0) : (w_fm_cnt != '0);
    assign w_pool_head = (r_in.pool == POOL_SSG) ? 4'(w_ssg_head) : 4'(w_fm_head);
    assign w_is_rel    = (r_mode == MODE_RELEASE);

    // match rule for the scan, fixed for the whole item
    always_comb begin
        if (w_is_rel) begin
            w_pred = r_in.midi ? (w_head.midi && w_head.knum == r_in.knum)
                               : (!w_head.midi && w_head.kcode == r_in.kcode);
        end else if (w_cnt_pos) begin
            w_pred = !r_in.midi && !w_head.midi && w_head.pool == r_in.pool &&
                     w_head.kcode == r_in.kcode;
        end else begin
            w_pred = (w_head.pool == r_in.pool);
        end
    end
    assign w_hit_now = w_step && !r_found && w_pred;

    always_comb begin
        w_replace = r_found;
        w_fresh   = !r_found && w_cnt_pos && (r_len < CW'(D));
        w_none    = !w_is_rel && !w_replace && !w_fresh;
        w_new       = r_in;
        w_new.voice = !r_poly ? r_in.chan : (w_replace ? r_hit.voice : w_pool_head);
    end

    // queue control: the scan pops the head and puts it back at the tail unless it matched
    always_comb begin
        if (w_step) begin
            w_q_push    = !w_hit_now;
            w_tail      = r_len - CW'(1);
            w_push_note = w_head;
        end else begin
            w_q_push    = w_commit && !w_is_rel && (w_replace || w_fresh);
            w_tail      = r_len;
            w_push_note = w_new;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++) begin : g_cell
            t_note w_next;
            if (gi == D - 1) begin : g_end
                assign w_next = w_cell[gi];
            end else begin : g_mid
                assign w_next = w_cell[gi+1];
            end
            assign w_cctrl[gi].shift = w_step;
            assign w_cctrl[gi].load  = w_q_push && (w_tail == CW'(gi));
            vas_note_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_cctrl[gi]),
                .i_next (w_next),
                .i_new  (w_push_note),
                .o_q    (w_cell[gi])
            );
        end
    endgenerate

    always_comb begin
        w_fm_ctrl.rebuild  = i_cfg_we;
        w_fm_ctrl.poly     = i_cfg_wdata;
        w_fm_ctrl.pop      = w_commit && !w_is_rel && w_fresh && r_in.pool == POOL_FM;
        w_fm_ctrl.push     = w_commit && w_is_rel && r_found && r_hit.pool == POOL_FM;
        w_ssg_ctrl.rebuild = i_cfg_we;
        w_ssg_ctrl.poly    = i_cfg_wdata;
        w_ssg_ctrl.pop     = w_commit && !w_is_rel && w_fresh && r_in.pool == POOL_SSG;
        w_ssg_ctrl.push    = w_commit && w_is_rel && r_found && r_hit.pool == POOL_SSG;
    end

    vas_free_list #(.N(FM_VOICES), .LW(FM_LW), .CNTW(FM_CW)) u_fm_list (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_fm_ctrl),
        .i_push_voice (r_hit.voice[FM_LW-1:0]),
        .o_head       (w_fm_head),
        .o_count      (w_fm_cnt)
    );

    vas_free_list #(.N(SSG_VOICES), .LW(SSG_LW), .CNTW(SSG_CW)) u_ssg_list (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ssg_ctrl),
        .i_push_voice (r_hit.voice[SSG_LW-1:0]),
        .o_head       (w_ssg_head),
        .o_count      (w_ssg_cnt)
    );

    // result items built at commit
    always_comb begin
        n_res0 = r_res0;
        n_res1 = r_res1;
        n_two  = r_two;
        if (w_is_rel) begin
            n_res0.kind  = r_found ? KIND_REL : KIND_NONE;
            n_res0.midi  = r_in.midi;
            n_res0.kcode = r_in.kcode;
            n_res0.knum  = r_in.knum;
            n_res0.chan  = 4'd0;
            n_res0.pool  = r_found ? r_hit.pool : POOL_FM;
            n_res0.voice = r_found ? r_hit.voice : 4'd0;
            n_two        = 1'b0;
        end else begin
            n_res0.kind  = KIND_START;
            n_res0.midi  = w_new.midi;
            n_res0.kcode = w_new.kcode;
            n_res0.knum  = w_new.knum;
            n_res0.chan  = w_new.chan;
            n_res0.pool  = w_new.pool;
            n_res0.voice = w_new.voice;
            n_res1.kind  = KIND_STEAL;
            n_res1.midi  = r_hit.midi;
            n_res1.kcode = r_hit.kcode;
            n_res1.knum  = r_hit.knum;
            n_res1.chan  = r_hit.chan;
            n_res1.pool  = r_hit.pool;
            n_res1.voice = r_hit.voice;
            n_two        = w_replace;
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        w_accept = 1'b0;
        w_step   = 1'b0;
        w_commit = 1'b0;
        w_load0  = 1'b0;
        w_load1  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_accept = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_step == r_n) begin
                    n_state = ST_COMMIT;
                end else begin
                    w_step = 1'b1;
                end
            end
            ST_COMMIT: begin
                w_commit = 1'b1;
                n_state  = w_none ? ST_IDLE : ST_EMIT0;
            end
            ST_EMIT0: begin
                if (w_out_free) begin
                    w_load0 = 1'b1;
                    n_state = r_two ? ST_EMIT1 : ST_IDLE;
                end
            end
            ST_EMIT1: begin
                if (w_out_free) begin
                    w_load1 = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= 1'b1;
            r_len       <= '0;
            r_step      <= '0;
            r_n         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_poly <= i_cfg_wdata;
                r_len  <= '0;
            end else if (w_hit_now) begin
                r_len <= r_len - CW'(1);
            end else if (w_commit && w_q_push) begin
                r_len <= r_len + CW'(1);
            end
            if (w_accept) begin
                r_step  <= '0;
                r_n     <= r_len;
                r_found <= 1'b0;
            end else if (w_step) begin
                r_step <= r_step + CW'(1);
                if (w_hit_now) begin
                    r_found <= 1'b1;
                end
            end
            if (w_load0 || w_load1) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode      <= s_axis_tuser[0];
            r_in.midi   <= s_axis_tuser[1];
            r_in.kcode  <= s_axis_tdata[4:0];
            r_in.knum   <= s_axis_tdata[11:5];
            r_in.chan   <= s_axis_tdata[15:12];
            r_in.pool   <= s_axis_tdata[16];
            r_in.voice  <= 4'd0;
        end
        if (w_hit_now) begin
            r_hit <= w_head;
        end
        if (w_commit) begin
            r_res0 <= n_res0;
            r_res1 <= n_res1;
            r_two  <= n_two;
        end
        if (w_load0) begin
            r_out      <= r_res0;
            r_out_last <= !r_two;
        end else if (w_load1) begin
            r_out      <= r_res1;
            r_out_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.voice, r_out.pool, r_out.chan, r_out.knum, r_out.kcode};
    assign m_axis_tuser  = {r_out.midi, r_out.kind};
    assign m_axis_tlast  = r_out_last;

endmodule

### bench/tb_voice_allocator_with_stealing_unit.sv
`timescale 1ns / 1ps
// tb_voice_allocator_with_stealing_unit: self-checking bench for the voice allocator
// drives key items from a directed table and then random phases in both modes, and
// predicts every result item; depends on vas_pkg and voice_allocator_with_stealing_unit
module tb_voice_allocator_with_stealing_unit;
    import vas_pkg::*;

    localparam int FM_VOICES     = 6;
    localparam int SSG_VOICES    = 3;
    localparam int TABLE_DEPTH   = FM_VOICES + SSG_VOICES;
    localparam int LIST_SLOTS    = 16;
    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam int STUCK_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 400;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 240;
    localparam int CALM_ITEMS    = 150;
    localparam int MAX_PRINTS    = 40;
    localparam int DUE_SLOTS     = 64;

    typedef struct packed {
        t_res res;
        logic last;
    } t_event;

    typedef struct packed {
        logic       is_cfg;
        logic       cfg_val;
        logic       mode;
        logic       midi;
        logic [4:0] kcode;
        logic [6:0] knum;
        logic [3:0] chan;
        logic       pool;
        logic       typed;
        t_kind      exp_kind;
        logic [3:0] exp_voice;
    } t_row;

    localparam int N_DIR = 28;
    // cfg, val, mode, midi, key_code, key_number, channel, pool, typed, kind, voice
    localparam t_row DIR_TAB [N_DIR] = '{
        '{1'b0, 1'b0, MODE_RELEASE, 1'b0, 5'd5,  7'd0,   4'd0,  POOL_FM,  1'b1, KIND_NONE,  4'd0},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b1, 5'd29, 7'd127, 4'd15, POOL_FM,  1'b1, KIND_NONE,  4'd0},
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd0,  7'd127, 4'd15, POOL_FM,  1'b1, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd29, 7'd0,   4'd0,  POOL_FM,  1'b1, KIND_START, 4'd1},
        '{1'b0, 1'b0, MODE_PRESS,   1'b1, 5'd10, 7'd127, 4'd7,  POOL_FM,  1'b1, KIND_START, 4'd2},
        '{1'b0, 1'b0, MODE_PRESS,   1'b1, 5'd3,  7'd0,   4'd8,  POOL_FM,  1'b1, KIND_START, 4'd3},
        // same physical key again keeps its voice
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd0,  7'd64,  4'd3,  POOL_FM,  1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd0,  7'd1,   4'd2,  POOL_SSG, 1'b1, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_PRESS,   1'b1, 5'd1,  7'd60,  4'd4,  POOL_SSG, 1'b1, KIND_START, 4'd1},
        '{1'b0, 1'b0, MODE_PRESS,   1'b1, 5'd2,  7'd61,  4'd5,  POOL_SSG, 1'b1, KIND_START, 4'd2},
        // ssg pool empty: oldest ssg note loses its voice
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd7,  7'd9,   4'd6,  POOL_SSG, 1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd12, 7'd20,  4'd9,  POOL_FM,  1'b1, KIND_START, 4'd4},
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd13, 7'd21,  4'd10, POOL_FM,  1'b1, KIND_START, 4'd5},
        // table full and fm pool empty
        '{1'b0, 1'b0, MODE_PRESS,   1'b1, 5'd14, 7'd100, 4'd11, POOL_FM,  1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b1, 5'd0,  7'd127, 4'd1,  POOL_FM,  1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b0, 5'd29, 7'd3,   4'd2,  POOL_SSG, 1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b1, 5'd6,  7'd0,   4'd13, POOL_FM,  1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b0, 5'd0,  7'd2,   4'd14, POOL_SSG, 1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b1, 5'd29, 7'd127, 4'd0,  POOL_FM,  1'b0, KIND_START, 4'd0},
        // mono: voice is the channel, one note per pool
        '{1'b1, 1'b0, MODE_PRESS,   1'b0, 5'd0,  7'd0,   4'd0,  POOL_FM,  1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd5,  7'd0,   4'd9,  POOL_FM,  1'b1, KIND_START, 4'd9},
        '{1'b0, 1'b0, MODE_PRESS,   1'b1, 5'd0,  7'd40,  4'd3,  POOL_FM,  1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd5,  7'd5,   4'd12, POOL_SSG, 1'b1, KIND_START, 4'd12},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b0, 5'd5,  7'd0,   4'd0,  POOL_FM,  1'b0, KIND_START, 4'd0},
        // mode write drops every sounding note
        '{1'b1, 1'b1, MODE_PRESS,   1'b0, 5'd0,  7'd0,   4'd0,  POOL_FM,  1'b0, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b1, 5'd3,  7'd40,  4'd7,  POOL_FM,  1'b1, KIND_NONE,  4'd0},
        '{1'b0, 1'b0, MODE_PRESS,   1'b0, 5'd16, 7'd127, 4'd15, POOL_SSG, 1'b1, KIND_START, 4'd0},
        '{1'b0, 1'b0, MODE_RELEASE, 1'b0, 5'd16, 7'd0,   4'd0,  POOL_FM,  1'b0, KIND_START, 4'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // key_code, key_number, track_channel, pool, zero pad
    logic [1:0]  s_axis_tuser;   // mode, is_midi
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // out_key_code, out_key_number, out_track_channel,
                                 // out_pool, voice, zero pad
    logic [2:0]  m_axis_tuser;   // kind, out_is_midi
    logic        m_axis_tlast;

    voice_allocator_with_stealing_unit #(
        .FM_VOICES (FM_VOICES),
        .SSG_VOICES(SSG_VOICES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // allocator state as the bench sees it
    t_note      notes [LIST_SLOTS];
    int         note_cnt;
    logic [3:0] fm_free [LIST_SLOTS];
    logic [3:0] ssg_free [LIST_SLOTS];
    int         fm_avail;
    int         ssg_avail;
    logic       poly_on;

    // expected result items, ring with free-running write and read counts
    t_event due_ring [DUE_SLOTS];
    int     due_wr;
    int     due_rd;
    int     fail_count;
    int     results_checked;
    int     items_sent;
    int     mode_writes;
    int     steal_count;
    int     release_count;
    int     silent_count;
    int     stuck_cycles;
    bit     calm;

    function automatic int due_level();
        return due_wr - due_rd;
    endfunction

    function automatic void model_rebuild(logic poly);
        poly_on = poly;
        for (int i = 0; i < LIST_SLOTS; i++) begin
            fm_free[i]  = 4'd0;
            ssg_free[i] = 4'd0;
        end
        if (poly) begin
            for (int i = 0; i < FM_VOICES; i++) fm_free[i] = i[3:0];
            for (int i = 0; i < SSG_VOICES; i++) ssg_free[i] = i[3:0];
            fm_avail  = FM_VOICES;
            ssg_avail = SSG_VOICES;
        end else begin
            fm_avail  = 1;
            ssg_avail = 1;
        end
        note_cnt = 0;
    endfunction

    function automatic void queue_result(t_kind kind, t_note n, logic [3:0] chan, logic last);
        t_event ev;
        ev.res.kind  = kind;
        ev.res.midi  = n.midi;
        ev.res.kcode = n.kcode;
        ev.res.knum  = n.knum;
        ev.res.chan  = chan;
        ev.res.pool  = n.pool;
        ev.res.voice = n.voice;
        ev.last      = last;
        due_ring[due_wr % DUE_SLOTS] = ev;
        due_wr++;
    endfunction

    function automatic void drop_note(int idx);
        for (int i = idx; i + 1 < note_cnt; i++) notes[i] = notes[i + 1];
        note_cnt--;
    endfunction

    function automatic logic [3:0] take_voice(logic pool);
        logic [3:0] v;
        if (pool == POOL_SSG) begin
            v = ssg_free[0];
            for (int i = 0; i < LIST_SLOTS - 1; i++) ssg_free[i] = ssg_free[i + 1];
            ssg_avail--;
        end else begin
            v = fm_free[0];
            for (int i = 0; i < LIST_SLOTS - 1; i++) fm_free[i] = fm_free[i + 1];
            fm_avail--;
        end
        return v;
    endfunction

    // a freed voice goes to the front of its list
    function automatic void give_voice(logic pool, logic [3:0] v);
        if (pool == POOL_SSG) begin
            if (ssg_avail < LIST_SLOTS) begin
                for (int i = LIST_SLOTS - 1; i > 0; i--) ssg_free[i] = ssg_free[i - 1];
                ssg_free[0] = v;
                ssg_avail++;
            end
        end else begin
            if (fm_avail < LIST_SLOTS) begin
                for (int i = LIST_SLOTS - 1; i > 0; i--) fm_free[i] = fm_free[i - 1];
                fm_free[0] = v;
                fm_avail++;
            end
        end
    endfunction

    // new note takes the slot's voice, old note is reported as displaced
    function automatic void steal_slot(t_note on, int idx);
        t_note old;
        old = notes[idx];
        on.voice = poly_on ? old.voice : on.chan;
        queue_result(KIND_START, on, on.chan, 1'b0);
        queue_result(KIND_STEAL, old, old.chan, 1'b1);
        drop_note(idx);
        notes[note_cnt] = on;
        note_cnt++;
        steal_count++;
    endfunction

    function automatic void predict_press(t_note on);
        int         avail;
        logic [3:0] v;
        avail = (on.pool == POOL_SSG) ? ssg_avail : fm_avail;
        if (avail > 0) begin
            if (!on.midi) begin
                for (int i = 0; i < note_cnt; i++) begin
                    if (!notes[i].midi && notes[i].pool == on.pool &&
                        notes[i].kcode == on.kcode) begin
                        steal_slot(on, i);
                        return;
                    end
                end
            end
            if (note_cnt >= TABLE_DEPTH) return;
            v = take_voice(on.pool);
            on.voice = poly_on ? v : on.chan;
            notes[note_cnt] = on;
            note_cnt++;
            queue_result(KIND_START, on, on.chan, 1'b1);
            return;
        end
        for (int i = 0; i < note_cnt; i++) begin
            if (notes[i].pool == on.pool) begin
                steal_slot(on, i);
                return;
            end
        end
    endfunction

    function automatic void predict_release(t_note key);
        logic hit;
        for (int i = 0; i < note_cnt; i++) begin
            hit = key.midi ? (notes[i].midi && notes[i].knum == key.knum)
                           : (!notes[i].midi && notes[i].kcode == key.kcode);
            if (hit) begin
                key.pool  = notes[i].pool;
                key.voice = notes[i].voice;
                give_voice(notes[i].pool, notes[i].voice);
                drop_note(i);
                queue_result(KIND_REL, key, 4'd0, 1'b1);
                release_count++;
                return;
            end
        end
        key.pool  = POOL_FM;
        key.voice = 4'd0;
        queue_result(KIND_NONE, key, 4'd0, 1'b1);
        silent_count++;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS) $display("mismatch at result %0d: %s", results_checked, msg);
    endtask

    task automatic check_field(string name, int got_v, int want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("%s got %0d want %0d", name, got_v, want_v));
    endtask

    task automatic wait_drain();
        while (due_level() != 0) @(posedge i_clk);
    endtask

    task automatic send_item(logic mode, t_note key);
        s_axis_tdata  <= {7'd0, key.pool, key.chan, key.knum, key.kcode};
        s_axis_tuser  <= {key.midi, mode};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (mode == MODE_RELEASE) predict_release(key);
        else predict_press(key);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // mode writes only with the block idle
    task automatic write_mode(logic poly);
        s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= poly;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_rebuild(poly);
        mode_writes++;
    endtask

    task automatic send_random(int press_pct);
        logic  mode;
        t_note key;
        int    pick;
        mode      = ($urandom_range(0, 99) < press_pct) ? MODE_PRESS : MODE_RELEASE;
        key.midi  = 1'($urandom_range(0, 1));
        key.kcode = 5'($urandom_range(0, 29));
        key.knum  = 7'($urandom_range(0, 127));
        key.chan  = 4'($urandom_range(0, 15));
        key.pool  = 1'($urandom_range(0, 1));
        key.voice = 4'd0;
        // most releases and some presses hit a key that is sounding
        if (note_cnt > 0 && $urandom_range(0, 99) < (mode == MODE_RELEASE ? 85 : 30)) begin
            pick      = $urandom_range(0, note_cnt - 1);
            key.midi  = notes[pick].midi;
            key.kcode = notes[pick].kcode;
            key.knum  = notes[pick].knum;
            if (mode == MODE_PRESS) key.pool = notes[pick].pool;
        end
        send_item(mode, key);
    endtask

    always @(posedge i_clk) begin : result_check
        t_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_level() == 0) begin
                report_mismatch("result item with nothing outstanding");
            end else begin
                want = due_ring[due_rd % DUE_SLOTS];
                due_rd++;
                check_field("kind", m_axis_tuser[1:0], want.res.kind);
                check_field("is_midi", m_axis_tuser[2], want.res.midi);
                check_field("key_code", m_axis_tdata[4:0], want.res.kcode);
                check_field("key_number", m_axis_tdata[11:5], want.res.knum);
                check_field("track_channel", m_axis_tdata[15:12], want.res.chan);
                check_field("pool", m_axis_tdata[16], want.res.pool);
                check_field("voice", m_axis_tdata[20:17], want.res.voice);
                check_field("last", m_axis_tlast, want.last);
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, due_level());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // receiver: short random stalls, one long hold so the input backs up
    initial begin : sink
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm && !held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
                if (m_axis_tvalid && m_axis_tready) taken++;
            end
        end
    end

    initial begin : driver
        t_note  key;
        t_event typed;
        int     press_pct;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'd0;
        s_axis_tuser  = 2'd0;
        model_rebuild(1'b1);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_TAB[r].is_cfg) begin
                write_mode(DIR_TAB[r].cfg_val);
            end else begin
                key.midi  = DIR_TAB[r].midi;
                key.kcode = DIR_TAB[r].kcode;
                key.knum  = DIR_TAB[r].knum;
                key.chan  = DIR_TAB[r].chan;
                key.pool  = DIR_TAB[r].pool;
                key.voice = 4'd0;
                send_item(DIR_TAB[r].mode, key);
                // hand-written expectation replaces the predicted one
                if (DIR_TAB[r].typed) begin
                    typed.res.kind  = DIR_TAB[r].exp_kind;
                    typed.res.midi  = DIR_TAB[r].midi;
                    typed.res.kcode = DIR_TAB[r].kcode;
                    typed.res.knum  = DIR_TAB[r].knum;
                    typed.res.chan  = (DIR_TAB[r].exp_kind == KIND_START) ? DIR_TAB[r].chan : 4'd0;
                    typed.res.pool  = (DIR_TAB[r].exp_kind == KIND_START) ? DIR_TAB[r].pool
                                                                          : POOL_FM;
                    typed.res.voice = DIR_TAB[r].exp_voice;
                    typed.last      = 1'b1;
                    due_ring[(due_wr - 1) % DUE_SLOTS] = typed;
                end
                sender_gap();
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_mode((ph % 3 == 1) ? 1'b0 : 1'b1);
            press_pct = $urandom_range(35, 70);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == N_PHASES - 1 && n == PHASE_ITEMS - CALM_ITEMS) calm <= 1'b1;
                // sender holds back until every outstanding result is in
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drain();
                    @(posedge i_clk);
                end
                send_random(press_pct);
                sender_gap();
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d key items (%0d from the directed table), %0d results, %0d mode writes",
                 items_sent, N_DIR - 2, results_checked, mode_writes);
        $display("%0d voices stolen or reused, %0d notes released, %0d releases of silent keys",
                 steal_count, release_count, silent_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
